### hw/rtl/sha256_byte_stream_hasher_macros.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Included by files that hold concurrent assertions.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// implication checked on every edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

### hw/rtl/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: constants, types, round functions.
// No dependencies.
package sha_pkg;
	localparam int BlockBytes = 64;
	localparam int Rounds = 64;
	localparam logic [7:0] PadByte = 8'h80;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam logic [CfgIdxW-1:0] RegEnable = 3'd0;
	localparam logic [CfgIdxW-1:0] RegAb = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCd = 3'd2;
	localparam logic [CfgIdxW-1:0] RegEf = 3'd3;
	localparam logic [CfgIdxW-1:0] RegGh = 3'd4;
	localparam logic [CfgIdxW-1:0] RegBytes = 3'd5;

	localparam logic [31:0] InitValue [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_item_t;

	typedef enum logic [1:0] {
		SrcInput = 2'd0,
		SrcPad   = 2'd1,
		SrcZero  = 2'd2,
		SrcLen   = 2'd3
	} byte_src_t;

	// controller -> datapath
	typedef struct packed {
		logic      open_msg;
		logic      put;
		byte_src_t src;
		logic      count_byte;
		logic      latch_bits;
		logic      comp_start;
		logic      comp_round;
		logic      comp_finish;
		logic      out_shift;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round;
	} dp_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

### hw/rtl/sha_stream_if.sv
// Valid/ready stream interface with a generic payload type.
// Depends on nothing.
interface sha_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Depends on sha_pkg, sha_stream_if, sha_ctrl and sha_datapath.
// One byte is taken per cycle while idle, until a block fills; a full block
// then passes through the single round unit (one load, 64 rounds, one chain
// update), during which no byte is taken. End of message writes the pad, zero
// and length bytes one at a time, takes one step with no write to leave the
// zero fill, compresses each padding block, then makes eight digest
// transfers, word a first, digest_last on the eighth. Items with neither
// byte_valid nor end_of_message are taken and dropped.
module sha256_byte_stream_hasher (
	input  logic clk,
	input  logic arst_n,
	sha_stream_if.sink   in_s,
	sha_stream_if.source out_s,
	input  logic                          cfg_we,
	input  logic [sha_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sha_pkg::CfgDataW-1:0]  cfg_data
);
	sha_pkg::dp_cmd_t  cmd;
	sha_pkg::dp_stat_t stat;
	sha_pkg::in_item_t in_item;
	logic [31:0]       word;
	logic              last;

	assign in_item = in_s.payload;
	assign out_s.payload = '{digest_word: word, digest_last: last};

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_s.valid), .in_ready(in_s.ready),
		.byte_valid(in_item.byte_valid), .end_of_message(in_item.end_of_message),
		.out_valid(out_s.valid), .out_ready(out_s.ready), .digest_last(last),
		.cmd, .stat);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.data_byte(in_item.data_byte),
		.cfg_en(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.digest_word(word));
endmodule

### hw/rtl/sha_datapath.sv
// Datapath: block buffer, schedule window, working variables, chain value
// (rotated out as the digest) and length counter. Depends on sha_pkg.
module sha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::dp_cmd_t     cmd,
	output sha_pkg::dp_stat_t    stat,
	input  logic [7:0]           data_byte,
	input  logic                 cfg_en,
	input  logic [sha_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [sha_pkg::CfgDataW-1:0] cfg_data,
	output logic [31:0]          digest_word
);
	logic        mid_en_q;
	logic [63:0] mid_q [4];
	logic [63:0] mid_bytes_q;
	logic [31:0] chain_q [8];
	logic [31:0] wv_q [8];
	logic [31:0] win_q [16];
	logic [31:0] blk_q [16];
	logic [31:0] blk_word_q;
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] total_q;
	logic [63:0] bits_q;
	logic [63:0] start_total;
	logic [2:0]  len_idx;
	logic [7:0]  put_val;
	logic [31:0] w, t1, t2, s0, s1;
	logic [3:0]  rd_word;

	assign stat.fill = fill_q;
	assign stat.round = round_q;
	assign digest_word = chain_q[0];
	assign len_idx = fill_q[2:0];
	assign start_total = mid_en_q ? mid_bytes_q : 64'd0;

	always_comb begin
		case (cmd.src)
			sha_pkg::SrcInput: put_val = data_byte;
			sha_pkg::SrcPad:   put_val = sha_pkg::PadByte;
			sha_pkg::SrcZero:  put_val = 8'h00;
			sha_pkg::SrcLen:   put_val = bits_q[8*(7-len_idx) +: 8];
			default:           put_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_en_q <= 1'b0;
			mid_bytes_q <= '0;
			for (int i = 0; i < 4; i++) mid_q[i] <= '0;
		end else if (cfg_en) begin
			case (cfg_idx)
				sha_pkg::RegEnable: mid_en_q <= cfg_data[0];
				sha_pkg::RegAb:     mid_q[0] <= cfg_data;
				sha_pkg::RegCd:     mid_q[1] <= cfg_data;
				sha_pkg::RegEf:     mid_q[2] <= cfg_data;
				sha_pkg::RegGh:     mid_q[3] <= cfg_data;
				sha_pkg::RegBytes:  mid_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			round_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.put) fill_q <= (cmd.open_msg ? 6'd0 : fill_q) + 6'd1;
			else if (cmd.open_msg) fill_q <= '0;
			if (cmd.count_byte)
				total_q <= (cmd.open_msg ? start_total : total_q) + 64'd1;
			else if (cmd.open_msg) total_q <= start_total;
			if (cmd.comp_start) round_q <= '0;
			else if (cmd.comp_round) round_q <= round_q + 6'd1;
		end
	end

	// block buffer: 16 words, one byte lane written, one word read per cycle
	assign rd_word = cmd.comp_start ? 4'd0 : round_q[3:0] + 4'd1;
	always_ff @(posedge clk) begin
		if (cmd.put) blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= put_val;
		blk_word_q <= blk_q[rd_word];
	end

	always_comb begin
		s1 = sha_pkg::rotr(win_q[14], 17) ^ sha_pkg::rotr(win_q[14], 19)
			^ (win_q[14] >> 10);
		s0 = sha_pkg::rotr(win_q[1], 7) ^ sha_pkg::rotr(win_q[1], 18)
			^ (win_q[1] >> 3);
		w = (round_q < 6'd16) ? blk_word_q : s1 + win_q[9] + s0 + win_q[0];
		t1 = wv_q[7] + (sha_pkg::rotr(wv_q[4], 6) ^ sha_pkg::rotr(wv_q[4], 11)
			^ sha_pkg::rotr(wv_q[4], 25)) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ sha_pkg::RoundK[round_q] + w;
		t2 = (sha_pkg::rotr(wv_q[0], 2) ^ sha_pkg::rotr(wv_q[0], 13)
			^ sha_pkg::rotr(wv_q[0], 22))
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_bits) bits_q <= {total_q[60:0], 3'b000};
		if (cmd.open_msg) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[2*i]   <= mid_en_q ? mid_q[i][63:32] : sha_pkg::InitValue[2*i];
				chain_q[2*i+1] <= mid_en_q ? mid_q[i][31:0] : sha_pkg::InitValue[2*i+1];
			end
		end else if (cmd.comp_finish) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
		end else if (cmd.out_shift) begin
			for (int i = 0; i < 7; i++) chain_q[i] <= chain_q[i+1];
			chain_q[7] <= chain_q[0];
		end
		if (cmd.comp_start) begin
			for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
		end else if (cmd.comp_round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end
endmodule

### hw/rtl/sha_ctrl.sv
// Controller: accepts bytes, sequences compression, padding and digest output.
// Depends on sha_pkg and the assertion macros header.
`include "sha256_byte_stream_hasher_macros.svh"
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              byte_valid,
	input  logic              end_of_message,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              digest_last,
	output sha_pkg::dp_cmd_t  cmd,
	input  sha_pkg::dp_stat_t stat
);
	typedef enum logic [5:0] {
		StIdle  = 6'b000001,
		StPad   = 6'b000010,
		StZero  = 6'b000100,
		StLen   = 6'b001000,
		StComp  = 6'b010000,
		StOut   = 6'b100000
	} state_t;

	state_t     state_q, ret_q;
	logic       in_msg_q;
	logic       prime_q;
	logic       fin_q;
	logic [2:0] out_cnt_q;
	logic       take;
	logic       last_put;

	assign in_ready = (state_q == StIdle);
	assign take = in_valid && in_ready && (byte_valid || end_of_message);
	assign out_valid = (state_q == StOut);
	assign digest_last = (out_cnt_q == 3'd7);
	assign last_put = cmd.put && (stat.fill == 6'd63);

	always_comb begin
		cmd = '0;
		cmd.src = sha_pkg::SrcInput;
		case (state_q)
			StIdle: begin
				cmd.open_msg = take && !in_msg_q;
				cmd.put = take && byte_valid;
				cmd.count_byte = take && byte_valid;
			end
			StPad: begin
				cmd.src = sha_pkg::SrcPad;
				cmd.put = 1'b1;
				cmd.latch_bits = 1'b1;
			end
			StZero: begin
				cmd.src = sha_pkg::SrcZero;
				cmd.put = (stat.fill != 6'd56);
			end
			StLen: begin
				cmd.src = sha_pkg::SrcLen;
				cmd.put = 1'b1;
			end
			StComp: begin
				cmd.comp_start = prime_q;
				cmd.comp_round = !prime_q && !fin_q;
				cmd.comp_finish = fin_q;
			end
			StOut: cmd.out_shift = out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ret_q <= StIdle;
			in_msg_q <= 1'b0;
			prime_q <= 1'b0;
			fin_q <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			case (state_q)
				StIdle: if (take) begin
					in_msg_q <= 1'b1;
					if (last_put) begin
						state_q <= StComp;
						prime_q <= 1'b1;
						ret_q <= end_of_message ? StPad : StIdle;
					end else if (end_of_message) state_q <= StPad;
				end
				StPad: if (last_put) begin
					state_q <= StComp;
					prime_q <= 1'b1;
					ret_q <= StZero;
				end else state_q <= StZero;
				StZero: if (stat.fill == 6'd56) state_q <= StLen;
					else if (last_put) begin
						state_q <= StComp;
						prime_q <= 1'b1;
						ret_q <= StZero;
					end
				StLen: if (last_put) begin
					state_q <= StComp;
					prime_q <= 1'b1;
					ret_q <= StOut;
				end
				StComp: begin
					prime_q <= 1'b0;
					if (cmd.comp_round && stat.round == 6'd63) fin_q <= 1'b1;
					if (fin_q) begin
						fin_q <= 1'b0;
						state_q <= ret_q;
					end
				end
				StOut: if (out_ready) begin
					out_cnt_q <= out_cnt_q + 3'd1;
					if (digest_last) begin
						state_q <= StIdle;
						in_msg_q <= 1'b0;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_out_only_idle_free, clk, arst_n, out_valid, !in_ready)
	`SHA_ASSERT_NEXT(a_len_to_comp, clk, arst_n, state_q == StLen && stat.fill == 6'd63,
		state_q == StComp)
	`SHA_ASSERT_IMP(a_zero_stop, clk, arst_n, state_q == StZero && stat.fill == 6'd56,
		!cmd.put)
	`SHA_ASSERT_NEXT(a_last_ends_out, clk, arst_n, out_valid && out_ready && digest_last,
		state_q == StIdle)
endmodule
